// ===== src/stt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

  // Token kinds as they leave the block.
  typedef enum logic [4:0] {
    KIND_EOF       = 5'd0,
    KIND_IDENT     = 5'd1,
    KIND_NUMERAL   = 5'd2,
    KIND_LBRACE    = 5'd3,
    KIND_RBRACE    = 5'd4,
    KIND_LPAREN    = 5'd5,
    KIND_RPAREN    = 5'd6,
    KIND_SEMI      = 5'd7,
    KIND_PLUS      = 5'd8,
    KIND_MINUS     = 5'd9,
    KIND_STAR      = 5'd10,
    KIND_SLASH     = 5'd11,
    KIND_AND_AND   = 5'd12,
    KIND_OR_OR     = 5'd13,
    KIND_GE        = 5'd14,
    KIND_GT        = 5'd15,
    KIND_LE        = 5'd16,
    KIND_LT        = 5'd17,
    KIND_EQ_EQ     = 5'd18,
    KIND_ASSIGN    = 5'd19,
    KIND_NE        = 5'd20,
    KIND_BANG      = 5'd21,
    KIND_KW_CODE   = 5'd22,
    KIND_KW_ELSE   = 5'd23,
    KIND_KW_FALSE  = 5'd24,
    KIND_KW_IF     = 5'd25,
    KIND_KW_PRINT  = 5'd26,
    KIND_KW_TRUE   = 5'd27,
    KIND_KW_VARS   = 5'd28,
    KIND_KW_WHILE  = 5'd29,
    KIND_UNKNOWN   = 5'd30
  } kind_e;

  // Scanner mode, one-hot.
  typedef enum logic [3:0] {
    MODE_IDLE    = 4'b0001,
    MODE_COMMENT = 4'b0010,
    MODE_WORD    = 4'b0100,
    MODE_NUMBER  = 4'b1000
  } mode_e;

  // First byte of a possible two-byte operator.
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_AMP  = 3'd1,
    OP_BAR  = 3'd2,
    OP_GT   = 3'd3,
    OP_LT   = 3'd4,
    OP_EQ   = 3'd5,
    OP_BANG = 3'd6
  } op_e;

  localparam int unsigned START_W   = 32;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned NUM_W     = 31;

  typedef struct packed {
    kind_e              token_kind;
    logic [NUM_W-1:0]   numeral_value;
    logic [START_W-1:0] token_start;
    logic [LEN_W-1:0]   token_length;
    logic               last_token;
  } token_t;

  localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_BAR  = 8'h7C;
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_ZERO = 8'h30;

  localparam int unsigned KW_COUNT   = 8;
  localparam int unsigned KW_MAX_LEN = 9;

  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
    '{"c", "o", "d", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"p", "r", "i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"v", "a", "r", "i", "a", "b", "l", "e", "s"},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{
    16'd4, 16'd4, 16'd5, 16'd2, 16'd5, 16'd4, 16'd9, 16'd5
  };

  localparam kind_e KW_KIND [KW_COUNT] = '{
    KIND_KW_CODE, KIND_KW_ELSE, KIND_KW_FALSE, KIND_KW_IF,
    KIND_KW_PRINT, KIND_KW_TRUE, KIND_KW_VARS, KIND_KW_WHILE
  };

  // Kind of a pending operator byte that stands alone.
  function automatic kind_e op_single(input op_e op);
    kind_e k;
    case (op)
      OP_GT:   k = KIND_GT;
      OP_LT:   k = KIND_LT;
      OP_EQ:   k = KIND_ASSIGN;
      OP_BANG: k = KIND_BANG;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  // Kind of a pending operator completed by its second byte.
  function automatic kind_e op_double(input op_e op);
    kind_e k;
    case (op)
      OP_AMP:  k = KIND_AND_AND;
      OP_BAR:  k = KIND_OR_OR;
      OP_GT:   k = KIND_GE;
      OP_LT:   k = KIND_LE;
      OP_EQ:   k = KIND_EQ_EQ;
      OP_BANG: k = KIND_NE;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] op_second(input op_e op);
    logic [7:0] c;
    case (op)
      OP_AMP:  c = CH_AMP;
      OP_BAR:  c = CH_BAR;
      OP_GT, OP_LT, OP_EQ, OP_BANG: c = CH_EQ;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/stt_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Byte request channel into the tokenizer.
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_stream;

  modport source (output valid, output source_byte, output end_of_stream, input ready);
  modport sink   (input valid, input source_byte, input end_of_stream, output ready);
endinterface

// Token request channel out of the tokenizer.
interface stt_out_if;
  logic                            valid;
  logic                            ready;
  stt_pkg::kind_e                  token_kind;
  logic [stt_pkg::NUM_W-1:0]       numeral_value;
  logic [stt_pkg::START_W-1:0]     token_start;
  logic [stt_pkg::LEN_W-1:0]       token_length;
  logic                            last_token;

  modport source (output valid, output token_kind, output numeral_value,
                  output token_start, output token_length, output last_token,
                  input ready);
  modport sink   (input valid, input token_kind, input numeral_value,
                  input token_start, input token_length, input last_token,
                  output ready);
endinterface

`default_nettype wire

// ===== src/source_text_tokenizer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Streaming lexer: one source byte per request on in_i, tokens on out_o.
// in_i carries source_byte and end_of_stream. A byte may close the current
// run and start a one-byte token, so it gives zero, one or two tokens;
// last_token marks the final token belonging to that byte. An end-of-stream
// request flushes any open run, emits EOF (length 0) and rewinds offsets to 0.
// A token enters the token queue as the byte that ends it is accepted and
// shows on out_o once the tokens ahead of it have left. Throughput: one byte
// per cycle while the receiver is ready and every byte gives at most one
// token; the output side moves one token per cycle, the limit when bytes
// produce two. A four-entry token queue decouples the two sides.
// in_i.ready is high while at least two queue slots are free, so a stalled
// receiver fills the queue and then holds off new bytes; nothing is dropped.
// Reset clears the scan mode, offsets and queue; the word buffer is only read
// after the current word has written it.
module source_text_tokenizer #(
  parameter int unsigned KEYWORD_BUFFER_BYTES = 9,
  parameter int unsigned OFFSET_BITS          = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  stt_in_if.sink     in_i,
  stt_out_if.source  out_o
);

  logic             in_accept;
  logic             room;
  logic [1:0]       push_count;
  stt_pkg::token_t  tok0;
  stt_pkg::token_t  tok1;

  assign in_i.ready = room;
  assign in_accept  = in_i.valid && in_i.ready;

  stt_scanner #(
    .KEYWORD_BUFFER_BYTES (KEYWORD_BUFFER_BYTES),
    .OFFSET_BITS          (OFFSET_BITS)
  ) u_scanner (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (in_accept),
    .source_byte_i   (in_i.source_byte),
    .end_of_stream_i (in_i.end_of_stream),
    .tok0_o          (tok0),
    .tok1_o          (tok1),
    .push_count_o    (push_count)
  );

  stt_token_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_count_i (push_count),
    .tok0_i       (tok0),
    .tok1_i       (tok1),
    .room_o       (room),
    .out_o        (out_o)
  );

  // the token group of each byte closes with exactly one last marker
  a_last_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_count == 2'd1) |-> tok0.last_token)
    else $error("single token without last marker");

  a_last_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_count == 2'd2) |-> (!tok0.last_token && tok1.last_token))
    else $error("token pair with wrong last markers");

  // end of stream always ends in EOF
  a_eof_pushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_i.end_of_stream) |->
      ((push_count == 2'd1 && tok0.token_kind == stt_pkg::KIND_EOF) ||
       (push_count == 2'd2 && tok1.token_kind == stt_pkg::KIND_EOF)))
    else $error("end of stream without EOF token");

  a_eof_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.token_kind == stt_pkg::KIND_EOF) |->
      (out_o.token_length == '0 && out_o.last_token))
    else $error("EOF token with nonzero length or not last");

endmodule

`default_nettype wire

// ===== src/stt_scanner.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stt_scanner #(
  parameter int unsigned KEYWORD_BUFFER_BYTES = 9,
  parameter int unsigned OFFSET_BITS          = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [7:0]      source_byte_i,
  input  wire logic            end_of_stream_i,
  output stt_pkg::token_t      tok0_o,
  output stt_pkg::token_t      tok1_o,
  output logic [1:0]           push_count_o
);

  localparam int unsigned BufIdxW = $clog2(KEYWORD_BUFFER_BYTES);
  localparam int unsigned LenW    = stt_pkg::LEN_W;
  localparam int unsigned NumW    = stt_pkg::NUM_W;

  stt_pkg::mode_e          mode_q, mode_d;
  stt_pkg::op_e            op_q, op_d;
  logic [7:0]              kw_buf_q [KEYWORD_BUFFER_BYTES];
  logic [LenW-1:0]         run_len_q, run_len_d;
  logic [OFFSET_BITS-1:0]  run_start_q, run_start_d;
  logic [OFFSET_BITS-1:0]  offset_q, offset_d;
  logic [NumW-1:0]         acc_q, acc_d;

  logic                    kw_we;
  logic [BufIdxW-1:0]      kw_idx;

  logic                    is_space, is_letter, is_digit, is_newline;
  stt_pkg::op_e            char_op;
  stt_pkg::kind_e          punct_kind;
  stt_pkg::kind_e          word_kind;
  logic [LenW-1:0]         len_inc;
  logic [NumW+3:0]         acc_wide;
  logic [NumW-1:0]         acc_sat;
  logic [3:0]              digit_val;

  logic                    flush_vld;
  stt_pkg::token_t         flush_tok;
  logic                    do_flush, do_idle;
  logic                    a_vld, b_vld;
  stt_pkg::token_t         b_tok;
  logic                    kw_hit;

  // Byte classes
  always_comb begin
    is_space   = source_byte_i inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    is_letter  = source_byte_i inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    is_digit   = source_byte_i inside {[8'h30:8'h39]};
    is_newline = (source_byte_i == stt_pkg::CH_LF) || (source_byte_i == stt_pkg::CH_CR);
    digit_val  = 4'(source_byte_i - stt_pkg::CH_ZERO);
  end

  always_comb begin
    case (source_byte_i)
      stt_pkg::CH_AMP:  char_op = stt_pkg::OP_AMP;
      stt_pkg::CH_BAR:  char_op = stt_pkg::OP_BAR;
      stt_pkg::CH_GT:   char_op = stt_pkg::OP_GT;
      stt_pkg::CH_LT:   char_op = stt_pkg::OP_LT;
      stt_pkg::CH_EQ:   char_op = stt_pkg::OP_EQ;
      stt_pkg::CH_BANG: char_op = stt_pkg::OP_BANG;
      default:          char_op = stt_pkg::OP_NONE;
    endcase
  end

  always_comb begin
    case (source_byte_i)
      "{":     punct_kind = stt_pkg::KIND_LBRACE;
      "}":     punct_kind = stt_pkg::KIND_RBRACE;
      "(":     punct_kind = stt_pkg::KIND_LPAREN;
      ")":     punct_kind = stt_pkg::KIND_RPAREN;
      ";":     punct_kind = stt_pkg::KIND_SEMI;
      "+":     punct_kind = stt_pkg::KIND_PLUS;
      "-":     punct_kind = stt_pkg::KIND_MINUS;
      "*":     punct_kind = stt_pkg::KIND_STAR;
      "/":     punct_kind = stt_pkg::KIND_SLASH;
      default: punct_kind = stt_pkg::KIND_UNKNOWN;
    endcase
  end

  // Keyword compare: eight independent matches against the word buffer.
  always_comb begin
    word_kind = stt_pkg::KIND_IDENT;
    for (int k = stt_pkg::KW_COUNT - 1; k >= 0; k--) begin
      kw_hit = (run_len_q == stt_pkg::KW_LEN[k]);
      for (int j = 0; j < stt_pkg::KW_MAX_LEN; j++) begin
        if ((16'(j) < stt_pkg::KW_LEN[k]) && (kw_buf_q[j] != stt_pkg::KW_TEXT[k][j])) begin
          kw_hit = 1'b0;
        end
      end
      if (kw_hit) begin
        word_kind = stt_pkg::KW_KIND[k];
      end
    end
  end

  // Saturating run length and decimal accumulate (x*10 = x*8 + x*2)
  always_comb begin
    len_inc  = (run_len_q == stt_pkg::LEN_MAX) ? stt_pkg::LEN_MAX : run_len_q + 1'b1;
    acc_wide = {3'b000, acc_q, 1'b0} + {acc_q, 3'b000} + {(NumW)'(0), digit_val};
    acc_sat  = (acc_wide > {4'b0000, stt_pkg::NUM_MAX}) ? stt_pkg::NUM_MAX : acc_wide[NumW-1:0];
  end

  // Token left open by the current run
  always_comb begin
    flush_tok               = '0;
    flush_tok.token_start   = stt_pkg::START_W'(run_start_q);
    flush_tok.token_length  = run_len_q;
    flush_vld               = 1'b1;
    if (op_q != stt_pkg::OP_NONE) begin
      flush_tok.token_kind   = stt_pkg::op_single(op_q);
      flush_tok.token_length = 16'd1;
    end else if (mode_q == stt_pkg::MODE_WORD) begin
      flush_tok.token_kind = word_kind;
    end else if (mode_q == stt_pkg::MODE_NUMBER) begin
      flush_tok.token_kind    = stt_pkg::KIND_NUMERAL;
      flush_tok.numeral_value = acc_q;
    end else begin
      flush_tok.token_kind = stt_pkg::KIND_EOF;
      flush_vld            = 1'b0;
    end
  end

  always_comb begin
    mode_d      = mode_q;
    op_d        = op_q;
    run_len_d   = run_len_q;
    run_start_d = run_start_q;
    acc_d       = acc_q;
    offset_d    = offset_q;
    kw_we       = 1'b0;
    kw_idx      = run_len_q[BufIdxW-1:0];
    do_flush    = 1'b0;
    do_idle     = 1'b0;
    b_vld       = 1'b0;
    b_tok       = '0;
    b_tok.token_start  = stt_pkg::START_W'(offset_q);
    b_tok.token_length = 16'd1;

    if (end_of_stream_i) begin
      do_flush           = 1'b1;
      b_vld              = 1'b1;
      b_tok.token_kind   = stt_pkg::KIND_EOF;
      b_tok.token_length = '0;
      mode_d             = stt_pkg::MODE_IDLE;
      op_d               = stt_pkg::OP_NONE;
      run_len_d          = '0;
      run_start_d        = '0;
      offset_d           = '0;
      acc_d              = '0;
    end else begin
      offset_d = offset_q + 1'b1;
      if (mode_q == stt_pkg::MODE_COMMENT) begin
        if (is_newline) begin
          mode_d = stt_pkg::MODE_IDLE;
        end
      end else if (op_q != stt_pkg::OP_NONE) begin
        if (source_byte_i == stt_pkg::op_second(op_q)) begin
          b_vld              = 1'b1;
          b_tok.token_kind   = stt_pkg::op_double(op_q);
          b_tok.token_start  = stt_pkg::START_W'(run_start_q);
          b_tok.token_length = 16'd2;
          op_d               = stt_pkg::OP_NONE;
        end else begin
          do_flush = 1'b1;
          do_idle  = 1'b1;
        end
      end else if (mode_q == stt_pkg::MODE_WORD) begin
        if (is_letter || is_digit) begin
          kw_we     = (run_len_q < LenW'(KEYWORD_BUFFER_BYTES));
          run_len_d = len_inc;
        end else begin
          do_flush = 1'b1;
          do_idle  = 1'b1;
        end
      end else if (mode_q == stt_pkg::MODE_NUMBER) begin
        if (is_digit) begin
          acc_d     = acc_sat;
          run_len_d = len_inc;
        end else begin
          do_flush = 1'b1;
          do_idle  = 1'b1;
        end
      end else begin
        do_idle = 1'b1;
      end

      if (do_flush) begin
        mode_d = stt_pkg::MODE_IDLE;
        op_d   = stt_pkg::OP_NONE;
      end

      if (do_idle && !is_space) begin
        if (source_byte_i == stt_pkg::CH_HASH) begin
          mode_d = stt_pkg::MODE_COMMENT;
        end else if (is_letter) begin
          mode_d      = stt_pkg::MODE_WORD;
          run_start_d = offset_q;
          run_len_d   = 16'd1;
          kw_we       = 1'b1;
          kw_idx      = '0;
        end else if (is_digit) begin
          mode_d      = stt_pkg::MODE_NUMBER;
          run_start_d = offset_q;
          run_len_d   = 16'd1;
          acc_d       = NumW'(digit_val);
        end else if (char_op != stt_pkg::OP_NONE) begin
          op_d        = char_op;
          run_start_d = offset_q;
        end else begin
          b_vld            = 1'b1;
          b_tok.token_kind = punct_kind;
        end
      end
    end
  end

  // Up to two tokens per byte: the flushed run first, then the new one.
  always_comb begin
    a_vld  = do_flush && flush_vld;
    tok0_o = a_vld ? flush_tok : b_tok;
    tok1_o = b_tok;
    tok0_o.last_token = !(a_vld && b_vld);
    tok1_o.last_token = 1'b1;
    push_count_o = accept_i ? ({1'b0, a_vld} + {1'b0, b_vld}) : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= stt_pkg::MODE_IDLE;
      op_q        <= stt_pkg::OP_NONE;
      run_len_q   <= '0;
      run_start_q <= '0;
      offset_q    <= '0;
      acc_q       <= '0;
    end else if (accept_i) begin
      mode_q      <= mode_d;
      op_q        <= op_d;
      run_len_q   <= run_len_d;
      run_start_q <= run_start_d;
      offset_q    <= offset_d;
      acc_q       <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && !end_of_stream_i && kw_we) begin
      kw_buf_q[kw_idx] <= source_byte_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/stt_token_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stt_token_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [1:0]  push_count_i,
  input  stt_pkg::token_t  tok0_i,
  input  stt_pkg::token_t  tok1_i,
  output logic             room_o,
  stt_out_if.source        out_o
);

  localparam int unsigned Depth = stt_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  stt_pkg::token_t  mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             pop;
  logic [PtrW-1:0]  wr_ptr_nxt;
  stt_pkg::token_t  head;

  always_comb begin
    pop        = out_o.valid && out_o.ready;
    wr_ptr_nxt = wr_ptr_q + 1'b1;
    wr_ptr_d   = wr_ptr_q + PtrW'(push_count_i);
    rd_ptr_d   = rd_ptr_q + PtrW'(pop);
    count_d    = count_q + CntW'(push_count_i) - CntW'(pop);
    // two free slots guarantee the worst case of one byte fits
    room_o     = (count_q <= CntW'(Depth - 2));
    head       = mem_q[rd_ptr_q];
  end

  assign out_o.valid         = (count_q != '0);
  assign out_o.token_kind    = head.token_kind;
  assign out_o.numeral_value = head.numeral_value;
  assign out_o.token_start   = head.token_start;
  assign out_o.token_length  = head.token_length;
  assign out_o.last_token    = head.last_token;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_count_i != 2'd0) begin
      mem_q[wr_ptr_q] <= tok0_i;
    end
    if (push_count_i == 2'd2) begin
      mem_q[wr_ptr_nxt] <= tok1_i;
    end
  end

endmodule

`default_nettype wire

// ===== bench/stt_token_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the tokenizer, lexes every accepted byte request
// on its own and compares each accepted token with the oldest one due.
module stt_token_checker #(
  parameter int unsigned KEYWORD_BUFFER_BYTES = 9
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  stt_in_if           in_mon,
  stt_out_if          out_mon,
  output int unsigned fail_count_o,
  output int unsigned tokens_due_o
);

  import stt_pkg::*;

  // Scanner state of the prediction.
  mode_e       scan_mode;
  op_e         pend_op;
  logic [7:0]  word_buf [KEYWORD_BUFFER_BYTES];
  logic [15:0] run_len;
  logic [31:0] run_start;
  logic [31:0] byte_pos;
  logic [30:0] num_acc;

  token_t      expected_tokens [$];
  int unsigned mismatches;
  int unsigned tokens_due;
  int unsigned step_tokens;

  assign fail_count_o = mismatches;
  assign tokens_due_o = tokens_due;

  function automatic logic is_blank(logic [7:0] b);
    return b == " " || b == 8'h09 || b == 8'h0A || b == 8'h0B || b == 8'h0C || b == 8'h0D;
  endfunction

  function automatic logic is_letter(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic [15:0] bump_len(logic [15:0] len);
    return (len == 16'hFFFF) ? len : len + 16'd1;
  endfunction

  function automatic op_e lead_op(logic [7:0] b);
    op_e op;
    case (b)
      "&":     op = OP_AMP;
      "|":     op = OP_BAR;
      ">":     op = OP_GT;
      "<":     op = OP_LT;
      "=":     op = OP_EQ;
      "!":     op = OP_BANG;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

  // Kind of a pending operator, alone or completed by its second byte.
  function automatic kind_e op_kind(op_e op, logic paired);
    kind_e k;
    case (op)
      OP_AMP:  k = paired ? KIND_AND_AND : KIND_UNKNOWN;
      OP_BAR:  k = paired ? KIND_OR_OR : KIND_UNKNOWN;
      OP_GT:   k = paired ? KIND_GE : KIND_GT;
      OP_LT:   k = paired ? KIND_LE : KIND_LT;
      OP_EQ:   k = paired ? KIND_EQ_EQ : KIND_ASSIGN;
      OP_BANG: k = paired ? KIND_NE : KIND_BANG;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] pair_byte(op_e op);
    return (op == OP_AMP) ? "&" : (op == OP_BAR) ? "|" : "=";
  endfunction

  // Keywords in kind order, code first.
  function automatic kind_e word_token();
    kind_e k;
    string kw;
    logic  hit;
    k = KIND_IDENT;
    if (run_len <= KEYWORD_BUFFER_BYTES) begin
      for (int i = 0; i < 8; i++) begin
        case (i)
          0: kw = "code";
          1: kw = "else";
          2: kw = "false";
          3: kw = "if";
          4: kw = "print";
          5: kw = "true";
          6: kw = "variables";
          default: kw = "while";
        endcase
        hit = (kw.len() == int'(run_len));
        for (int j = 0; j < kw.len(); j++) begin
          if (hit && word_buf[j] != kw[j]) hit = 1'b0;
        end
        if (hit) k = kind_e'(int'(KIND_KW_CODE) + i);
      end
    end
    return k;
  endfunction

  function automatic void queue_token(kind_e kind, logic [30:0] value, logic [31:0] start,
                                      logic [15:0] len);
    token_t t;
    t.token_kind    = kind;
    t.numeral_value = value;
    t.token_start   = start;
    t.token_length  = len;
    t.last_token    = 1'b0;
    expected_tokens.insert(expected_tokens.size(), t);
    step_tokens++;
  endfunction

  // Emit whatever run is still open; a comment just ends.
  function automatic void close_run();
    if (pend_op != OP_NONE)
      queue_token(op_kind(pend_op, 1'b0), '0, run_start, 16'd1);
    else if (scan_mode == MODE_WORD)
      queue_token(word_token(), '0, run_start, run_len);
    else if (scan_mode == MODE_NUMBER)
      queue_token(KIND_NUMERAL, num_acc, run_start, run_len);
    pend_op   = OP_NONE;
    scan_mode = MODE_IDLE;
  endfunction

  function automatic void open_token(logic [7:0] b);
    kind_e k;
    op_e   op;
    op = lead_op(b);
    if (!is_blank(b)) begin
      if (b == "#") begin
        scan_mode = MODE_COMMENT;
      end else if (is_letter(b)) begin
        scan_mode   = MODE_WORD;
        run_start   = byte_pos;
        run_len     = 16'd1;
        word_buf[0] = b;
      end else if (is_digit(b)) begin
        scan_mode = MODE_NUMBER;
        run_start = byte_pos;
        run_len   = 16'd1;
        num_acc   = 31'(b - "0");
      end else if (op != OP_NONE) begin
        pend_op   = op;
        run_start = byte_pos;
      end else begin
        case (b)
          "{":     k = KIND_LBRACE;
          "}":     k = KIND_RBRACE;
          "(":     k = KIND_LPAREN;
          ")":     k = KIND_RPAREN;
          ";":     k = KIND_SEMI;
          "+":     k = KIND_PLUS;
          "-":     k = KIND_MINUS;
          "*":     k = KIND_STAR;
          "/":     k = KIND_SLASH;
          default: k = KIND_UNKNOWN;
        endcase
        queue_token(k, '0, byte_pos, 16'd1);
      end
    end
  endfunction

  function automatic void lex_byte(logic [7:0] b);
    logic        absorbed;
    logic [63:0] grown;
    absorbed = 1'b0;
    if (scan_mode == MODE_COMMENT) begin
      if (b == 8'h0A || b == 8'h0D) scan_mode = MODE_IDLE;
      absorbed = 1'b1;
    end else if (pend_op != OP_NONE) begin
      if (b == pair_byte(pend_op)) begin
        queue_token(op_kind(pend_op, 1'b1), '0, run_start, 16'd2);
        pend_op  = OP_NONE;
        absorbed = 1'b1;
      end else begin
        close_run();
      end
    end else if (scan_mode == MODE_WORD) begin
      if (is_letter(b) || is_digit(b)) begin
        if (run_len < KEYWORD_BUFFER_BYTES) word_buf[int'(run_len)] = b;
        run_len  = bump_len(run_len);
        absorbed = 1'b1;
      end else begin
        close_run();
      end
    end else if (scan_mode == MODE_NUMBER) begin
      if (is_digit(b)) begin
        grown    = 64'(num_acc) * 64'd10 + 64'(b - "0");
        num_acc  = (grown > 64'h7FFF_FFFF) ? '1 : grown[30:0];
        run_len  = bump_len(run_len);
        absorbed = 1'b1;
      end else begin
        close_run();
      end
    end
    if (!absorbed) open_token(b);
  endfunction

  function automatic void clear_scanner();
    scan_mode = MODE_IDLE;
    pend_op   = OP_NONE;
    run_len   = '0;
    run_start = '0;
    byte_pos  = '0;
    num_acc   = '0;
    foreach (word_buf[i]) word_buf[i] = '0;
  endfunction

  function automatic void compare_token(token_t want, token_t got);
    if (got.token_kind != want.token_kind) begin
      $error("token_kind: expected %0d, got %0d", want.token_kind, got.token_kind);
      mismatches++;
    end
    if (got.numeral_value != want.numeral_value) begin
      $error("numeral_value: expected %0d, got %0d", want.numeral_value, got.numeral_value);
      mismatches++;
    end
    if (got.token_start != want.token_start) begin
      $error("token_start: expected %0d, got %0d", want.token_start, got.token_start);
      mismatches++;
    end
    if (got.token_length != want.token_length) begin
      $error("token_length: expected %0d, got %0d", want.token_length, got.token_length);
      mismatches++;
    end
    if (got.last_token != want.last_token) begin
      $error("last_token: expected %0d, got %0d", want.last_token, got.last_token);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    token_t got;
    token_t want;
    if (!rst_ni) begin
      clear_scanner();
      expected_tokens.delete();
      mismatches = 0;
      tokens_due = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        step_tokens = 0;
        if (in_mon.end_of_stream) begin
          close_run();
          queue_token(KIND_EOF, '0, byte_pos, '0);
          clear_scanner();
        end else begin
          lex_byte(in_mon.source_byte);
          byte_pos = byte_pos + 32'd1;
        end
        if (step_tokens > 0) begin
          expected_tokens[expected_tokens.size() - 1].last_token = 1'b1;
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        got.token_kind    = out_mon.token_kind;
        got.numeral_value = out_mon.numeral_value;
        got.token_start   = out_mon.token_start;
        got.token_length  = out_mon.token_length;
        got.last_token    = out_mon.last_token;
        if (expected_tokens.size() == 0) begin
          $error("unexpected token: kind %0d at offset %0d", got.token_kind, got.token_start);
          mismatches++;
        end else begin
          want = expected_tokens.pop_front();
          compare_token(want, got);
        end
      end
      tokens_due = expected_tokens.size();
    end
  end

endmodule

// ===== bench/source_text_tokenizer_test.sv =====
`timescale 1ns / 1ps

// Top of the tokenizer bench: clock, reset, byte stimulus and a randomly
// stalling token receiver. All checking lives in stt_token_checker; this
// module only waits for it to drain and reports the verdict.
module source_text_tokenizer_test;

  logic clk_i;
  logic rst_ni;

  stt_in_if  in_ch ();
  stt_out_if out_ch ();

  int unsigned fail_count;
  int unsigned tokens_due;

  // Idle chances in percent, changed per phase.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // Pending byte requests: bit 8 is end_of_stream, bits 7:0 the source byte.
  logic [8:0] byte_q [$];

  source_text_tokenizer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  stt_token_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .tokens_due_o (tokens_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop; the slowest legal run (two tokens per byte, both sides
  // stalling) stays well below this.
  initial begin
    #(1_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  // Token receiver: ready redrawn every cycle from the current stall chance.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---- byte stream builders --------------------------------------------

  function automatic void add_byte(logic [7:0] b);
    byte_q.insert(byte_q.size(), {1'b0, b});
  endfunction

  // End of stream; the byte lane carries junk, which the block must ignore.
  function automatic void add_eos();
    byte_q.insert(byte_q.size(), {1'b1, 8'($urandom)});
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic logic [7:0] rand_letter();
    return $urandom_range(1) ? 8'("a" + $urandom_range(25)) : 8'("A" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_alnum();
    return ($urandom_range(2) == 0) ? rand_digit() : rand_letter();
  endfunction

  // Space, TAB, LF, VT, FF or CR.
  function automatic logic [7:0] rand_blank();
    logic [7:0] b;
    case ($urandom_range(5))
      0:       b = " ";
      1:       b = 8'h09;
      2:       b = 8'h0A;
      3:       b = 8'h0B;
      4:       b = 8'h0C;
      default: b = 8'h0D;
    endcase
    return b;
  endfunction

  // Any byte but the two that close a comment.
  function automatic logic [7:0] comment_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == 8'h0A || b == 8'h0D);
    return b;
  endfunction

  function automatic string kw_text(int unsigned i);
    string s;
    case (i)
      0:       s = "code";
      1:       s = "else";
      2:       s = "false";
      3:       s = "if";
      4:       s = "print";
      5:       s = "true";
      6:       s = "variables";
      default: s = "while";
    endcase
    return s;
  endfunction

  // Operators and punctuation, lone & and | included.
  function automatic string op_text(int unsigned i);
    string s;
    case (i)
      0:       s = "&&";
      1:       s = "||";
      2:       s = ">=";
      3:       s = "<=";
      4:       s = "==";
      5:       s = "!=";
      6:       s = ">";
      7:       s = "<";
      8:       s = "=";
      9:       s = "!";
      10:      s = "&";
      11:      s = "|";
      12:      s = "{";
      13:      s = "}";
      14:      s = "(";
      15:      s = ")";
      16:      s = ";";
      17:      s = "+";
      18:      s = "-";
      19:      s = "*";
      default: s = "/";
    endcase
    return s;
  endfunction

  // One lexeme of mostly well-formed text, then maybe a separator.
  // Leaving the separator out makes tokens abut, which exercises maximal munch.
  function automatic void add_random_token();
    int unsigned pick;
    int unsigned n;
    string       kw;
    pick = $urandom_range(99);
    if (pick < 14) begin
      add_text(kw_text($urandom_range(7)));
    end else if (pick < 26) begin
      if ($urandom_range(3) == 0) begin
        // keyword prefix plus tail: near misses and long words
        kw = kw_text($urandom_range(7));
        n  = $urandom_range(1, kw.len());
        for (int i = 0; i < int'(n); i++) add_byte(kw[i]);
        repeat ($urandom_range(2)) add_byte(rand_alnum());
      end else begin
        add_byte(rand_letter());
        repeat ($urandom_range(11)) add_byte(rand_alnum());
      end
    end else if (pick < 38) begin
      case ($urandom_range(5))
        0:       add_text("2147483647");
        1:       add_text("2147483648");
        2:       repeat ($urandom_range(11, 13)) add_byte("9");
        default: repeat ($urandom_range(1, 6)) add_byte(rand_digit());
      endcase
    end else if (pick < 58) begin
      add_text(op_text($urandom_range(20)));
    end else if (pick < 66) begin
      add_byte("#");
      repeat ($urandom_range(6)) add_byte(comment_byte());
      case ($urandom_range(3))
        0:       add_byte(8'h0A);
        1:       add_byte(8'h0D);
        2:       add_eos();
        default: ;  // left open: following text is swallowed until a line end
      endcase
    end else if (pick < 76) begin
      add_byte(8'($urandom));
    end else if (pick < 80) begin
      add_eos();
    end else begin
      repeat ($urandom_range(1, 3)) add_byte(rand_blank());
    end
    if ($urandom_range(9) < 6) add_byte(rand_blank());
  endfunction

  // ---- driver -----------------------------------------------------------

  // One byte request: random idle cycles first, then hold until accepted.
  task automatic send_request(input logic [8:0] item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.end_of_stream <= item[8];
    in_ch.source_byte   <= item[7:0];
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic drain_byte_queue();
    while (byte_q.size() > 0) send_request(byte_q.pop_front());
  endtask

  initial begin
    in_ch.valid         <= 1'b0;
    in_ch.source_byte   <= '0;
    in_ch.end_of_stream <= 1'b0;
    rst_ni              <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: keyword flushed by an operator, && and ||, word flushed by a
    // pending '=' which a '{' then closes (two tokens from one byte), lone &
    // and lone | each followed by a token, unknown bytes at both ends of the
    // range, numeral closed by >=, lone < closed by a comment, a comment cut
    // off by end of stream, and a word flushed together with EOF.
    add_text("if&&||x1={&a|;");
    add_byte(8'h00);
    add_byte(8'hFF);
    add_text("9>=<#c");
    add_eos();
    add_text("ab");
    add_eos();
    drain_byte_queue();

    // Random phases: no idling, idle sender, stalling receiver, both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      while (byte_q.size() < 205) add_random_token();
      drain_byte_queue();
    end
    in_ch.valid <= 1'b0;

    // Drain: every predicted token must arrive, then a quiet wait catches any
    // stray extra tokens.
    do @(negedge clk_i); while (tokens_due != 0);
    repeat (8) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/stt_pkg.sv
src/stt_if.sv
src/stt_scanner.sv
src/stt_token_queue.sv
src/source_text_tokenizer.sv
bench/stt_token_checker.sv
bench/source_text_tokenizer_test.sv
